// ----- design/pcomp_pkg.sv -----
// Shared types and constants for the pressure/temperature compensation block.
// Used by every module under design/ except pcomp_fifo; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pcomp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CAL_TEMP    = 2'd0;
    localparam logic [1:0] REG_CAL_PRESS_A = 2'd1;
    localparam logic [1:0] REG_CAL_PRESS_B = 2'd2;
    localparam logic [1:0] REG_CAL_NINTH   = 2'd3;

    // Compensation constants
    localparam int FINE_OFFSET = 128000;
    localparam int NUM_BIAS    = 1048576;
    localparam int NUM_SCALE   = 3125;
    localparam int TEMP_ROUND  = 256;
    localparam int PRESS_ROUND = 128;
    localparam logic [23:0] PRESS_MAX = 24'hFFFFFF;

    // Divider geometry: 64-bit dividend, divisor magnitude below 2^31
    localparam int QW = 64;
    localparam int DW = 31;

    // Unpacked calibration coefficients
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    // Item handed from the front part to the back part
    typedef struct packed {
        logic signed [15:0]   temp;
        logic signed [QW-1:0] num;
        logic signed [DW-1:0] den;
        logic                 dz;
    } qentry_t;

    // Side data that travels along the divider
    typedef struct packed {
        logic signed [15:0] temp;
        logic               dz;
        logic               neg;
    } div_side_t;

endpackage

`default_nettype wire

// ----- design/pcomp_fifo.sv -----
// Small register queue between the front and back parts.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pcomp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/pcomp_front.sv -----
// Front part: accepts raw readings, forms the fine temperature, the output
// temperature and the divisor/numerator of the pressure polynomial. Uses pcomp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcomp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [19:0]       raw_pressure,
    input  wire logic [19:0]       raw_temperature,
    input  wire pcomp_pkg::cal_t   cal,
    input  wire logic              q_full,
    output logic                   q_push,
    output pcomp_pkg::qentry_t     q_data
);

    localparam int NSTG = 8;

    logic            en;
    logic [NSTG-1:0] vld_reg;

    // Stage payload registers
    logic [19:0]        adc1_reg, adc2_reg, adc3_reg, adc4_reg, adc5_reg, adc6_reg;
    logic signed [33:0] m1_reg, m1_next, sq_reg, sq_next;
    logic signed [22:0] v1_reg, v1_next;
    logic signed [37:0] m2_reg, m2_next;
    logic signed [15:0] tmp3_reg, tmp4_reg, tmp5_reg, tmp6_reg, tmp7_reg, tmp8_reg;
    logic signed [15:0] tmp_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [63:0] aa_reg, aa_next;
    logic signed [47:0] ap5_reg, ap5_next, ap2_reg, ap2_next;
    logic signed [63:0] b6_reg, b6_next, a3_reg, a3_next;
    logic signed [63:0] bp_reg, bp_next, a2p_reg, a2p_next;
    logic signed [63:0] b_reg, b_next, x_reg, x_next;
    logic signed [63:0] y_reg, y_next, nb_reg, nb_next;
    logic signed [63:0] num_reg, num_next;
    logic signed [30:0] den_reg, den_next;

    // Combinational helpers
    logic signed [17:0] d1;
    logic signed [16:0] d2;
    logic signed [31:0] fine;
    logic [20:0]        pp;

    assign en       = !vld_reg[NSTG-1] || !q_full;
    assign in_stall = !en;
    assign q_push   = vld_reg[NSTG-1] && !q_full;

    assign q_data.temp = tmp8_reg;
    assign q_data.num  = num_reg;
    assign q_data.den  = den_reg;
    assign q_data.dz   = (den_reg == '0);

    // Datapath between stages
    always_comb
    begin
        d1 = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
        d2 = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
        m1_next = d1 * $signed(cal.t2);
        sq_next = d2 * d2;

        v1_next = 23'(m1_reg >>> 11);
        m2_next = $signed(22'(sq_reg >>> 12)) * $signed(cal.t3);

        fine     = 32'(v1_reg) + 32'(m2_reg >>> 14);
        tmp_next = 16'((fine + 32'(pcomp_pkg::TEMP_ROUND)) >>> 9);
        a_next   = fine - 32'(pcomp_pkg::FINE_OFFSET);

        aa_next  = a_reg * a_reg;
        ap5_next = a_reg * $signed(cal.p5);
        ap2_next = a_reg * $signed(cal.p2);

        b6_next  = aa_reg * 64'($signed(cal.p6));
        a3_next  = aa_reg * 64'($signed(cal.p3));
        bp_next  = (64'(ap5_reg) <<< 17) + (64'($signed(cal.p4)) <<< 35);
        a2p_next = 64'(ap2_reg) <<< 12;

        b_next = b6_reg + bp_reg;
        x_next = (64'sd1 <<< 47) + (a3_reg >>> 8) + a2p_reg;

        y_next  = x_reg * $signed({48'd0, cal.p1});
        pp      = 21'(pcomp_pkg::NUM_BIAS) - {1'b0, adc6_reg};
        nb_next = $signed(64'(pp) << 31) - b_reg;

        num_next = nb_reg * 64'(pcomp_pkg::NUM_SCALE);
        den_next = $signed(y_reg[63:33]);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adc1_reg <= raw_pressure;
            m1_reg   <= m1_next;
            sq_reg   <= sq_next;
            adc2_reg <= adc1_reg;
            v1_reg   <= v1_next;
            m2_reg   <= m2_next;
            adc3_reg <= adc2_reg;
            tmp3_reg <= tmp_next;
            a_reg    <= a_next;
            adc4_reg <= adc3_reg;
            tmp4_reg <= tmp3_reg;
            aa_reg   <= aa_next;
            ap5_reg  <= ap5_next;
            ap2_reg  <= ap2_next;
            adc5_reg <= adc4_reg;
            tmp5_reg <= tmp4_reg;
            b6_reg   <= b6_next;
            a3_reg   <= a3_next;
            bp_reg   <= bp_next;
            a2p_reg  <= a2p_next;
            adc6_reg <= adc5_reg;
            tmp6_reg <= tmp5_reg;
            b_reg    <= b_next;
            x_reg    <= x_next;
            tmp7_reg <= tmp6_reg;
            y_reg    <= y_next;
            nb_reg   <= nb_next;
            tmp8_reg <= tmp7_reg;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/pcomp_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses pcomp_pkg for widths and the side-data type.
`timescale 1ns / 1ps
`default_nettype none

module pcomp_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [pcomp_pkg::QW-1:0]       dividend,
    input  wire logic [pcomp_pkg::DW-1:0]       divisor,
    input  wire pcomp_pkg::div_side_t           side_in,
    output logic                                out_valid,
    output logic [pcomp_pkg::QW-1:0]            quotient,
    output pcomp_pkg::div_side_t                side_out
);

    localparam int QW = pcomp_pkg::QW;
    localparam int DW = pcomp_pkg::DW;

    // Per stage: shifting dividend/quotient word, partial remainder, divisor
    logic [QW-1:0]        acc_reg  [QW];
    logic [DW-1:0]        rem_reg  [QW];
    logic [DW-1:0]        dsr_reg  [QW];
    pcomp_pkg::div_side_t side_reg [QW];
    logic [QW-1:0]        vld_reg;

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [QW-1:0]        acc_in, acc_next;
            logic [DW-1:0]        rem_in, rem_next, dsr_in;
            logic [DW+1:0]        diff;
            logic                 ge, vin;
            pcomp_pkg::div_side_t sd_in;

            if (k == 0)
            begin : g_first
                assign acc_in = dividend;
                assign rem_in = '0;
                assign dsr_in = divisor;
                assign sd_in  = side_in;
                assign vin    = in_valid;
            end
            else
            begin : g_rest
                assign acc_in = acc_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign dsr_in = dsr_reg[k-1];
                assign sd_in  = side_reg[k-1];
                assign vin    = vld_reg[k-1];
            end

            // Trial subtract of the shifted remainder
            always_comb
            begin
                diff     = {1'b0, rem_in, acc_in[QW-1]} - {2'b00, dsr_in};
                ge       = !diff[DW+1];
                rem_next = ge ? diff[DW-1:0] : {rem_in[DW-2:0], acc_in[QW-1]};
                acc_next = {acc_in[QW-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vin;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg[k]  <= acc_next;
                    rem_reg[k]  <= rem_next;
                    dsr_reg[k]  <= dsr_in;
                    side_reg[k] <= sd_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign quotient  = acc_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

`default_nettype wire

// ----- design/pcomp_back.sv -----
// Back part: signed division, pressure correction terms, rounding and
// saturation, output register. Uses pcomp_pkg and pcomp_div.
`timescale 1ns / 1ps
`default_nettype none

module pcomp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    output logic                     q_pop,
    input  wire pcomp_pkg::qentry_t  q_data,
    input  wire pcomp_pkg::cal_t     cal,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [15:0]       temperature_decideg,
    output logic [23:0]              pressure_pa,
    output logic                     divisor_zero
);

    localparam int QW = pcomp_pkg::QW;
    localparam int DW = pcomp_pkg::DW;
    localparam int NT = 5;

    logic en;

    // Sign split stage
    logic                 pv_reg;
    logic [QW-1:0]        ma_reg, ma_next;
    logic [DW-1:0]        mb_reg, mb_next;
    pcomp_pkg::div_side_t ps_reg, ps_next;

    // Divider outputs
    logic                 dv;
    logic [QW-1:0]        quot;
    pcomp_pkg::div_side_t dside;

    // Tail stages
    logic [NT-1:0]        tv_reg;
    pcomp_pkg::div_side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic signed [63:0]   p1_reg, p1_next, p2_reg, p3_reg, p4_reg;
    logic [63:0]          ll_reg, ll_next;
    logic [31:0]          cr_reg, cr_next;
    logic signed [63:0]   c2m_reg, c2m_next;
    logic signed [63:0]   sq_reg, sq_next, c2a_reg, c2a_next, c2b_reg;
    logic signed [63:0]   c1m_reg, c1m_next;
    logic signed [63:0]   pt_reg, pt_next;
    logic signed [63:0]   pscl, rnd;
    logic [23:0]          pr_next;

    // Output register
    logic                 ov_reg;
    logic signed [15:0]   ot_reg;
    logic [23:0]          op_reg;
    logic                 oz_reg;

    assign en    = !ov_reg || !out_stall;
    assign q_pop = en && !q_empty;

    assign out_valid           = ov_reg;
    assign temperature_decideg = ot_reg;
    assign pressure_pa         = op_reg;
    assign divisor_zero        = oz_reg;

    // Take magnitudes for the unsigned divider
    always_comb
    begin
        ma_next      = q_data.num[QW-1] ? (QW'(0) - q_data.num) : q_data.num;
        mb_next      = q_data.den[DW-1] ? (DW'(0) - q_data.den) : q_data.den;
        ps_next.temp = q_data.temp;
        ps_next.dz   = q_data.dz;
        ps_next.neg  = q_data.num[QW-1] ^ q_data.den[DW-1];
    end

    pcomp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv_reg),
        .dividend  (ma_reg),
        .divisor   (mb_reg),
        .side_in   (ps_reg),
        .out_valid (dv),
        .quotient  (quot),
        .side_out  (dside)
    );

    // Correction terms and final scaling
    always_comb
    begin
        p1_next  = dside.neg ? -$signed(quot) : $signed(quot);

        pscl     = p1_reg >>> 13;
        ll_next  = pscl[31:0] * pscl[31:0];
        cr_next  = 32'(pscl[31:0] * pscl[63:32]);
        c2m_next = p1_reg * 64'($signed(cal.p8));

        sq_next  = $signed(ll_reg + (64'(cr_reg) << 33));
        c2a_next = c2m_reg >>> 19;

        c1m_next = sq_reg * 64'($signed(cal.p9));

        pt_next  = ((p4_reg + (c1m_reg >>> 25) + c2b_reg) >>> 8)
                   + (64'($signed(cal.p7)) <<< 4);

        rnd = (pt_reg + 64'(pcomp_pkg::PRESS_ROUND)) >>> 8;
        priority if (s5_reg.dz || rnd[63])
        begin
            pr_next = '0;
        end
        else if (rnd > $signed({40'd0, pcomp_pkg::PRESS_MAX}))
        begin
            pr_next = pcomp_pkg::PRESS_MAX;
        end
        else
        begin
            pr_next = rnd[23:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            tv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= !q_empty;
            tv_reg <= {tv_reg[NT-2:0], dv};
            ov_reg <= tv_reg[NT-1];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
            ps_reg  <= ps_next;
            s1_reg  <= dside;
            p1_reg  <= p1_next;
            s2_reg  <= s1_reg;
            p2_reg  <= p1_reg;
            ll_reg  <= ll_next;
            cr_reg  <= cr_next;
            c2m_reg <= c2m_next;
            s3_reg  <= s2_reg;
            p3_reg  <= p2_reg;
            sq_reg  <= sq_next;
            c2a_reg <= c2a_next;
            s4_reg  <= s3_reg;
            p4_reg  <= p3_reg;
            c1m_reg <= c1m_next;
            c2b_reg <= c2a_reg;
            s5_reg  <= s4_reg;
            pt_reg  <= pt_next;
            ot_reg  <= s5_reg.temp;
            op_reg  <= pr_next;
            oz_reg  <= s5_reg.dz;
        end
    end

endmodule

`default_nettype wire

// ----- design/pressure_temp_compensation_unit.sv -----
// Pressure/temperature compensation, top level: APB calibration registers,
// front part, queue and back part. Uses pcomp_pkg, pcomp_front, pcomp_fifo, pcomp_back.
//
// Usage:
//   Input channel (in_valid/in_stall, raw_pressure, raw_temperature) takes one
//   pair of raw readings per transfer. Output channel (out_valid/out_stall,
//   temperature_decideg, pressure_pa, divisor_zero) gives one result per item,
//   in order. Calibration must be written over the APB port (8-byte register
//   spacing, pready always high) only while no item is in flight; the block
//   does not enforce this. Throughput is one item per cycle while neither
//   stall is raised. Items pass 8 front stages, the queue, one sign stage,
//   64 divider stages (one quotient bit each) and 6 tail stages including
//   the output register. The front and back pipelines each freeze as a unit
//   on their own stall: out_stall holds the back part while the front keeps
//   filling the queue until it is full, then in_stall rises.
//   Reset clears the calibration registers, all valid bits and the queue;
//   no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pressure_temp_compensation_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [19:0]        raw_pressure,
    input  wire logic [19:0]        raw_temperature,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      temperature_decideg,
    output logic [23:0]             pressure_pa,
    output logic                    divisor_zero
);

    localparam int QEW = $bits(pcomp_pkg::qentry_t);

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg;
    logic [63:0] cal_press_b_reg;
    logic [15:0] cal_ninth_reg;
    logic [1:0]  idx;

    pcomp_pkg::cal_t    cal;
    pcomp_pkg::qentry_t q_wdata, q_rdata;
    logic               q_push, q_pop, q_full, q_empty;

    assign pready = 1'b1;
    assign idx    = paddr[4:3];

    // Write calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_ninth_reg   <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                pcomp_pkg::REG_CAL_TEMP:    cal_temp_reg    <= pwdata[47:0];
                pcomp_pkg::REG_CAL_PRESS_A: cal_press_a_reg <= pwdata;
                pcomp_pkg::REG_CAL_PRESS_B: cal_press_b_reg <= pwdata;
                pcomp_pkg::REG_CAL_NINTH:   cal_ninth_reg   <= pwdata[15:0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            pcomp_pkg::REG_CAL_TEMP:    prdata = {16'd0, cal_temp_reg};
            pcomp_pkg::REG_CAL_PRESS_A: prdata = cal_press_a_reg;
            pcomp_pkg::REG_CAL_PRESS_B: prdata = cal_press_b_reg;
            pcomp_pkg::REG_CAL_NINTH:   prdata = {48'd0, cal_ninth_reg};
        endcase
    end

    // Split packed coefficients
    always_comb
    begin
        cal.t1 = cal_temp_reg[15:0];
        cal.t2 = cal_temp_reg[31:16];
        cal.t3 = cal_temp_reg[47:32];
        cal.p1 = cal_press_a_reg[15:0];
        cal.p2 = cal_press_a_reg[31:16];
        cal.p3 = cal_press_a_reg[47:32];
        cal.p4 = cal_press_a_reg[63:48];
        cal.p5 = cal_press_b_reg[15:0];
        cal.p6 = cal_press_b_reg[31:16];
        cal.p7 = cal_press_b_reg[47:32];
        cal.p8 = cal_press_b_reg[63:48];
        cal.p9 = cal_ninth_reg;
    end

    pcomp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .cal             (cal),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_data          (q_wdata)
    );

    pcomp_fifo #(
        .WIDTH (QEW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    pcomp_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_empty             (q_empty),
        .q_pop               (q_pop),
        .q_data              (q_rdata),
        .cal                 (cal),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .temperature_decideg (temperature_decideg),
        .pressure_pa         (pressure_pa),
        .divisor_zero        (divisor_zero)
    );

endmodule

`default_nettype wire

// ----- dv/pressure_temp_compensation_unit_test.sv -----
// Testbench for pressure_temp_compensation_unit: APB calibration, directed
// table and random readings, checked against an in-bench compensation model.
// Depends on pcomp_pkg and the design sources only.
`timescale 1ns / 1ps

module pressure_temp_compensation_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic [19:0] raw_p;
        logic [19:0] raw_t;
        logic        has_fixed;
        logic [15:0] fixed_temp;
        logic [23:0] fixed_press;
        logic        fixed_dz;
    } reading_row_t;

    typedef struct packed {
        logic [15:0] temp;
        logic [23:0] press;
        logic        dz;
    } comp_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic [19:0] raw_pressure, raw_temperature;
    logic        out_valid, out_stall;
    logic signed [15:0] temperature_decideg;
    logic [23:0] pressure_pa;
    logic        divisor_zero;

    // Shadow calibration
    logic [47:0] sh_temp;
    logic [63:0] sh_press_a, sh_press_b;
    logic [15:0] sh_ninth;

    comp_result_t expected_results[$];
    int  fail_count;
    int  result_count;
    int  dz_count;
    int  cycle_count;
    bit  hold_off;
    reading_row_t reading_table[$];

    pressure_temp_compensation_unit dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] sx(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] shr(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    // Compute the compensated result from the shadow calibration
    function automatic comp_result_t compensate(input logic [19:0] rp, input logic [19:0] rt);
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] d1, v1, d2, v2, fine, a, b, num, q, ps, c1, c2, p, r;
        logic [63:0] ma, mb;
        comp_result_t res;
        t1 = {48'd0, sh_temp[15:0]};
        t2 = sx(sh_temp[31:16]);
        t3 = sx(sh_temp[47:32]);
        p1 = {48'd0, sh_press_a[15:0]};
        p2 = sx(sh_press_a[31:16]);
        p3 = sx(sh_press_a[47:32]);
        p4 = sx(sh_press_a[63:48]);
        p5 = sx(sh_press_b[15:0]);
        p6 = sx(sh_press_b[31:16]);
        p7 = sx(sh_press_b[47:32]);
        p8 = sx(sh_press_b[63:48]);
        p9 = sx(sh_ninth);
        d1 = {44'd0, rt >> 3} - (t1 << 1);
        v1 = shr(d1 * t2, 11);
        d2 = {44'd0, rt >> 4} - t1;
        v2 = shr(shr(d2 * d2, 12) * t3, 14);
        fine = v1 + v2;
        res.temp = 16'(shr(fine + 64'd256, 9));
        a = fine - 64'd128000;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        a = shr(a * a * p3, 8) + ((a * p2) << 12);
        a = shr(((64'd1 << 47) + a) * p1, 33);
        res.press = '0;
        res.dz = 1'b0;
        if (a == 0)
            res.dz = 1'b1;
        else
        begin
            p = 64'd1048576 - {44'd0, rp};
            num = ((p << 31) - b) * 64'd3125;
            ma = num[63] ? -num : num;
            mb = a[63] ? -a : a;
            q = ma / mb;
            p = (num[63] != a[63]) ? -q : q;
            ps = shr(p, 13);
            c1 = shr(p9 * ps * ps, 25);
            c2 = shr(p8 * p, 19);
            p = shr(p + c1 + c2, 8) + (p7 << 4);
            r = shr(p + 64'd128, 8);
            if (r[63])
                res.press = '0;
            else if (r > 64'hFFFFFF)
                res.press = pcomp_pkg::PRESS_MAX;
            else
                res.press = r[23:0];
        end
        return res;
    endfunction

    // APB write: setup then access
    task automatic write_cal(input logic [1:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pcomp_pkg::REG_CAL_TEMP:    sh_temp = value[47:0];
            pcomp_pkg::REG_CAL_PRESS_A: sh_press_a = value;
            pcomp_pkg::REG_CAL_PRESS_B: sh_press_b = value;
            default:                    sh_ninth = value[15:0];
        endcase
    endtask

    task automatic write_all(input logic [47:0] ct, input logic [63:0] ca,
                             input logic [63:0] cb, input logic [15:0] cn);
        write_cal(pcomp_pkg::REG_CAL_TEMP, {16'd0, ct});
        write_cal(pcomp_pkg::REG_CAL_PRESS_A, ca);
        write_cal(pcomp_pkg::REG_CAL_PRESS_B, cb);
        write_cal(pcomp_pkg::REG_CAL_NINTH, {48'd0, cn});
    endtask

    // Wait for the pipeline to drain before touching registers
    task automatic wait_idle();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Pick an idle length: mostly short, a few long
    function automatic int gap_length();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        return g;
    endfunction

    // Offer one transfer and hold it until accepted
    task automatic send_reading(input logic [19:0] rp, input logic [19:0] rt,
                                input bit fixed, input comp_result_t fixed_res);
        comp_result_t exp_res;
        in_valid <= 1'b1;
        raw_pressure <= rp;
        raw_temperature <= rt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp_res = fixed ? fixed_res : compensate(rp, rt);
        expected_results.push_back(exp_res);
    endtask

    // Drop valid only when a real gap follows
    task automatic idle_input();
        int g;
        g = gap_length();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Well-formed calibration near a real sensor, with random spread
    task automatic random_typical_cal();
        write_all({16'($urandom_range(0, 200) - 100), 16'($urandom_range(26000, 27000)),
                   16'($urandom_range(27000, 29000))},
                  {16'($urandom_range(8000, 9000)), 16'($urandom_range(0, 9000)),
                   16'($urandom_range(0, 200) - 100), 16'($urandom_range(35000, 37000))},
                  {16'($urandom_range(0, 600) - 300), 16'($urandom_range(0, 60) - 30),
                   16'($urandom_range(0, 200)), 16'($urandom_range(0, 20000) - 10000)},
                  16'($urandom_range(0, 12000) - 6000));
    endtask

    // Receiver: random stalls and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_off)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 9) == 0)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 1) == 0)
            out_stall <= 1'b0;
    end

    // Check each transfer on the output against the oldest expectation
    always @(posedge clk)
    begin
        comp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                result_count++;
                if (divisor_zero)
                    dz_count++;
                if (temperature_decideg !== want.temp)
                begin
                    $error("temperature_decideg expected %0d got %0d",
                           $signed(want.temp), temperature_decideg);
                    fail_count++;
                end
                if (pressure_pa !== want.press)
                begin
                    $error("pressure_pa expected %0d got %0d", want.press, pressure_pa);
                    fail_count++;
                end
                if (divisor_zero !== want.dz)
                begin
                    $error("divisor_zero expected %0d got %0d", want.dz, divisor_zero);
                    fail_count++;
                end
            end
        end
    end

    // Hold the receiver off for a long stretch while input keeps flowing
    task automatic long_hold_off();
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    endtask

    function automatic reading_row_t row(input logic [19:0] rp, input logic [19:0] rt,
                                         input logic fx, input logic [15:0] ft,
                                         input logic [23:0] fp, input logic fd);
        reading_row_t r;
        r.raw_p = rp;
        r.raw_t = rt;
        r.has_fixed = fx;
        r.fixed_temp = ft;
        r.fixed_press = fp;
        r.fixed_dz = fd;
        return r;
    endfunction

    initial
    begin
        comp_result_t fixed_res;
        int n;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        raw_pressure = '0;
        raw_temperature = '0;
        hold_off = 1'b0;
        fail_count = 0;
        result_count = 0;
        dz_count = 0;
        cycle_count = 0;
        sh_temp = '0;
        sh_press_a = '0;
        sh_press_b = '0;
        sh_ninth = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // After reset every coefficient is zero: temperature 0, divisor zero
        reading_table.push_back(row(20'h00000, 20'h00000, 1'b1, 16'd0, 24'd0, 1'b1));
        reading_table.push_back(row(20'hFFFFF, 20'hFFFFF, 1'b1, 16'd0, 24'd0, 1'b1));
        reading_table.push_back(row(20'hAAAAA, 20'h55555, 1'b1, 16'd0, 24'd0, 1'b1));
        foreach (reading_table[i])
        begin
            fixed_res = {reading_table[i].fixed_temp, reading_table[i].fixed_press,
                         reading_table[i].fixed_dz};
            send_reading(reading_table[i].raw_p, reading_table[i].raw_t,
                         reading_table[i].has_fixed, fixed_res);
        end
        in_valid <= 1'b0;
        wait_idle();

        // Typical calibration, field extremes
        write_all({16'hFE0C, 16'd26435, 16'd27504}, {16'hD0F5, 16'hF3B1, 16'd24, 16'd36477},
                  {16'd249, 16'hFFF9, 16'd15500, 16'hD050}, 16'd6000);
        reading_table.delete();
        reading_table.push_back(row(20'd0, 20'd0, 1'b0, '0, '0, 1'b0));
        reading_table.push_back(row(20'hFFFFF, 20'hFFFFF, 1'b0, '0, '0, 1'b0));
        reading_table.push_back(row(20'd415148, 20'd519888, 1'b0, '0, '0, 1'b0));
        reading_table.push_back(row(20'd0, 20'hFFFFF, 1'b0, '0, '0, 1'b0));
        reading_table.push_back(row(20'hFFFFF, 20'd0, 1'b0, '0, '0, 1'b0));
        reading_table.push_back(row(20'h55555, 20'hAAAAA, 1'b0, '0, '0, 1'b0));
        foreach (reading_table[i])
            send_reading(reading_table[i].raw_p, reading_table[i].raw_t, 1'b0, '0);
        in_valid <= 1'b0;
        wait_idle();

        // Extreme coefficients: saturation and wrap paths
        write_all(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  16'hFFFF);
        for (n = 0; n < 4; n++)
            send_reading(n[0] ? 20'hFFFFF : 20'd0, n[1] ? 20'hFFFFF : 20'd0, 1'b0, '0);
        in_valid <= 1'b0;
        wait_idle();
        write_all(48'h8000_8000_0000, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_8000_7FFF_8000,
                  16'h8000);
        for (n = 0; n < 4; n++)
            send_reading(n[0] ? 20'hFFFFF : 20'd0, n[1] ? 20'hFFFFF : 20'd0, 1'b0, '0);
        in_valid <= 1'b0;
        wait_idle();

        // Random phases: mostly typical calibration, some fully random
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase % 3 == 2)
                write_all(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
                          {$urandom(), $urandom()}, 16'($urandom()));
            else
                random_typical_cal();
            if (phase == 4)
            begin
                fork
                    long_hold_off();
                join_none
            end
            for (int i = 0; i < 100; i++)
            begin
                send_reading(20'($urandom()), ($urandom_range(0, 3) == 0) ?
                             20'($urandom()) : 20'($urandom_range(400000, 600000)),
                             1'b0, '0);
                if ($urandom_range(0, 3) == 0)
                    idle_input();
            end
            in_valid <= 1'b0;
            wait_idle();
        end

        $display("Checked %0d results (%0d with zero divisor) over 14 calibrations.",
                 result_count, dz_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
